>>> hdl/frr_pkg.sv
// Shared types and constants for the fragment frame reassembler.
// Used by every module in hdl/; depends on nothing else.
package frr_pkg;

  localparam int unsigned FRAME_LEN = 25;
  localparam int unsigned SUM_LAST  = 22;
  localparam int unsigned POS_W     = 5;
  localparam int unsigned LEN_W     = 10;

  localparam logic [7:0] HEADER_BYTE = 8'hA5;
  localparam logic [7:0] FOOTER_BYTE = 8'h5A;

  typedef enum logic [2:0] {
    ST_OK         = 3'd0,
    ST_BAD_FOOTER = 3'd1,
    ST_BAD_CHECK  = 3'd2,
    ST_OVERFLOW   = 3'd3,
    ST_TOO_LONG   = 3'd4
  } status_t;

  typedef struct packed {
    logic             link;
    logic             first;
    logic [LEN_W-1:0] len;
    logic [7:0]       data;
  } item_t;

  typedef struct packed {
    status_t      status;
    logic [15:0]  speed_target;
    logic [16:0]  turn_target;
    logic [15:0]  stop_word;
    logic [31:0]  turn_gain_bits;
    logic [31:0]  prop_gain_bits;
    logic [31:0]  integ_gain_bits;
    logic [31:0]  deriv_gain_bits;
  } result_t;

endpackage

>>> hdl/frr_in_stage.sv
// Input register of the fragment frame reassembler.
// Depends on frr_pkg for the item type.
module frr_in_stage (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  input  frr_pkg::item_t in_item,
  input  logic          down_ready,
  output logic          fire,
  output frr_pkg::item_t item
);

  logic valid;

  assign fire     = valid & down_ready;
  assign in_ready = ~valid | down_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (in_ready) begin
      valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      item <= in_item;
    end
  end

endmodule

>>> hdl/frr_frame_core.sv
// Frame state, byte store and frame check of the fragment frame reassembler.
// Depends on frr_pkg for constants, item and result types.
module frr_frame_core (
  input  logic             clk,
  input  logic             rst,
  input  logic             fire,
  input  frr_pkg::item_t   item,
  output logic             res_valid,
  output frr_pkg::result_t res
);

  logic [7:0]              store [frr_pkg::FRAME_LEN];
  logic [frr_pkg::POS_W-1:0] pos, pos_next;
  logic                    skip, skip_next;
  logic [7:0]              sum, sum_next;

  logic                    wr_en;
  logic [frr_pkg::POS_W-1:0] wr_pos;
  logic                    produce;

  always_comb begin
    logic                      restart;
    logic [frr_pkg::POS_W-1:0] pos_eff;
    logic [7:0]                sum_eff;
    logic [frr_pkg::LEN_W:0]   end_pos;
    logic                      do_store;
    logic [15:0]               turn_raw;

    pos_next  = pos;
    skip_next = skip;
    sum_next  = sum;
    wr_en     = 1'b0;
    wr_pos    = '0;
    produce   = 1'b0;
    res       = '0;
    res.status = frr_pkg::ST_OK;

    restart  = item.data == frr_pkg::HEADER_BYTE;
    pos_eff  = pos;
    sum_eff  = sum;
    do_store = 1'b0;
    end_pos  = '0;
    turn_raw = {store[4], store[3]};

    if (fire && item.link) begin
      if (item.first) begin
        skip_next = 1'b0;
        if (item.len == '0) begin
          skip_next = 1'b1;
        end else if (item.len > frr_pkg::LEN_W'(frr_pkg::FRAME_LEN)) begin
          skip_next  = 1'b1;
          produce    = 1'b1;
          res.status = frr_pkg::ST_TOO_LONG;
        end else begin
          // A header byte opening a fragment starts the frame over.
          if (restart) begin
            pos_eff = '0;
            sum_eff = '0;
          end
          end_pos = (frr_pkg::LEN_W + 1)'(pos_eff) + {1'b0, item.len};
          if (end_pos > (frr_pkg::LEN_W + 1)'(frr_pkg::FRAME_LEN)) begin
            pos_next   = '0;
            sum_next   = '0;
            skip_next  = 1'b1;
            produce    = 1'b1;
            res.status = frr_pkg::ST_OVERFLOW;
          end else begin
            do_store = 1'b1;
          end
        end
      end else if (!skip) begin
        do_store = 1'b1;
      end
    end

    if (do_store) begin
      wr_en  = 1'b1;
      wr_pos = pos_eff;
      if (pos_eff >= frr_pkg::POS_W'(1) && pos_eff <= frr_pkg::POS_W'(frr_pkg::SUM_LAST)) begin
        sum_next = sum_eff + item.data;
      end else begin
        sum_next = sum_eff;
      end
      pos_next = pos_eff + frr_pkg::POS_W'(1);
      // The last byte completes the frame; it is the footer itself.
      if (pos_eff == frr_pkg::POS_W'(frr_pkg::FRAME_LEN - 1)) begin
        pos_next = '0;
        sum_next = '0;
        produce  = 1'b1;
        if (item.data != frr_pkg::FOOTER_BYTE) begin
          res.status = frr_pkg::ST_BAD_FOOTER;
        end else if (store[0] != frr_pkg::HEADER_BYTE ||
                     sum_eff != store[frr_pkg::FRAME_LEN-2]) begin
          res.status = frr_pkg::ST_BAD_CHECK;
        end else begin
          res.status          = frr_pkg::ST_OK;
          res.speed_target    = {store[2], store[1]};
          res.turn_target     = 17'd0 - {turn_raw[15], turn_raw};
          res.stop_word       = {store[6], store[5]};
          res.turn_gain_bits  = {store[10], store[9], store[8], store[7]};
          res.prop_gain_bits  = {store[14], store[13], store[12], store[11]};
          res.integ_gain_bits = {store[18], store[17], store[16], store[15]};
          res.deriv_gain_bits = {store[22], store[21], store[20], store[19]};
        end
      end
    end
  end

  assign res_valid = produce;

  always_ff @(posedge clk) begin
    if (rst) begin
      pos  <= '0;
      skip <= 1'b0;
      sum  <= '0;
    end else begin
      pos  <= pos_next;
      skip <= skip_next;
      sum  <= sum_next;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      store[wr_pos] <= item.data;
    end
  end

  a_pos_in_frame: assert property (@(posedge clk) disable iff (rst)
    pos < frr_pkg::POS_W'(frr_pkg::FRAME_LEN))
    else $error("write position left the frame");

  a_fail_clean: assert property (@(posedge clk) disable iff (rst)
    (res_valid && res.status != frr_pkg::ST_OK) |->
      (res.speed_target == '0 && res.turn_target == '0 && res.stop_word == '0 &&
       res.turn_gain_bits == '0 && res.deriv_gain_bits == '0))
    else $error("failed frame carries payload");

  a_restart_after_result: assert property (@(posedge clk) disable iff (rst)
    (res_valid && res.status != frr_pkg::ST_TOO_LONG) |=> (pos == '0 && sum == '0))
    else $error("frame not restarted after a result");

  a_no_result_idle: assert property (@(posedge clk) disable iff (rst)
    !fire |-> !res_valid)
    else $error("result without an item");

endmodule

>>> hdl/frr_out_stage.sv
// Result register of the fragment frame reassembler.
// Depends on frr_pkg for the result type.
module frr_out_stage (
  input  logic             clk,
  input  logic             rst,
  input  logic             load,
  input  frr_pkg::result_t res_in,
  output logic             free,
  output logic             out_valid,
  input  logic             out_ready,
  output frr_pkg::result_t res
);

  assign free = ~out_valid | out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= load | (out_valid & ~out_ready);
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res <= res_in;
    end
  end

endmodule

>>> hdl/fragment_frame_reassembler.sv
// Top level of the fragment frame reassembler; uses frr_pkg, frr_in_stage, frr_frame_core
// and frr_out_stage.
// A word that completes a frame or is rejected waits in the input register until the result
// register is free; its result is then registered there and drives m_tvalid.
// One word per cycle if no result waits; the frame check and store write fit one logic pass.
// Reset (rst, synchronous, active high) clears position, sum, skip and valid flags only.
module fragment_frame_reassembler (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  input  logic [23:0]  s_tdata,   // [9:0] fragment_length, [17:10] data_byte, rest zero
  input  logic [1:0]   s_tuser,   // [0] link_connected, [1] fragment_start
  output logic         m_tvalid,
  input  logic         m_tready,
  output logic [183:0] m_tdata,   // [15:0] speed_target, [32:16] turn_target,
                                  // [48:33] stop_word, [80:49] turn_gain_bits,
                                  // [112:81] prop_gain_bits, [144:113] integ_gain_bits,
                                  // [176:145] deriv_gain_bits, rest zero
  output logic [2:0]   m_tuser    // [2:0] status
);

  frr_pkg::item_t   in_item, item;
  frr_pkg::result_t core_res, res;
  logic             fire, res_valid, out_free;

  // Unpack the incoming word into the item fields.
  assign in_item.link  = s_tuser[0];
  assign in_item.first = s_tuser[1];
  assign in_item.len   = s_tdata[9:0];
  assign in_item.data  = s_tdata[17:10];

  // The input register advances only when the result register can take a result,
  // so a result is never lost and a waiting result still lets one word in.
  frr_in_stage u_in (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (s_tvalid),
    .in_ready   (s_tready),
    .in_item    (in_item),
    .down_ready (out_free),
    .fire       (fire),
    .item       (item)
  );

  // Position tracking, fragment accept or drop, store write and frame check.
  frr_frame_core u_core (
    .clk       (clk),
    .rst       (rst),
    .fire      (fire),
    .item      (item),
    .res_valid (res_valid),
    .res       (core_res)
  );

  frr_out_stage u_out (
    .clk       (clk),
    .rst       (rst),
    .load      (res_valid),
    .res_in    (core_res),
    .free      (out_free),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .res       (res)
  );

  assign m_tuser = res.status;
  assign m_tdata = {7'd0, res.deriv_gain_bits, res.integ_gain_bits, res.prop_gain_bits,
                    res.turn_gain_bits, res.stop_word, res.turn_target, res.speed_target};

endmodule
